// File: rtl/core/bs3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 3x3x3 box stencil core.
// No dependencies; every other file of the core imports this package.
package bs3_pkg;

   localparam int SampleWidth   = 32;
   localparam int ScaleWidth    = 16;
   localparam int CsrDataWidth  = 16;
   localparam int CsrIndexWidth = 3;
   localparam int StepWidth     = 8;
   localparam int ColPosWidth   = 8;
   localparam int RowPosWidth   = 8;
   localparam int PlanePosWidth = 10;

   // Growth of the partial sums: three, nine and twenty-seven samples.
   localparam int VertWidth  = SampleWidth + 2;
   localparam int ColWidth   = SampleWidth + 4;
   localparam int TotalWidth = SampleWidth + 5;
   localparam int ProdWidth  = TotalWidth + ScaleWidth + 1;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] CsrVolumeCols   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrVolumeRows   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrVolumePlanes = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrStepSize     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrSumScale     = 3'd4;

   localparam int                    DimReset   = 256;
   localparam int                    PlaneReset = 1024;
   localparam logic [StepWidth-1:0]  StepReset  = 8'd1;
   localparam logic [ScaleWidth-1:0] ScaleReset = 16'd2621;

   // Per-beat bookkeeping that travels with each sample down the pipeline.
   typedef struct packed {
      logic                     emit;
      logic                     last;
      logic [ColPosWidth-1:0]   col;
      logic [RowPosWidth-1:0]   row;
      logic [PlanePosWidth-1:0] plane;
   } meta_type;

endpackage

// File: rtl/core/bs3_ctrl.sv
`timescale 1ns / 1ps
// Configuration registers, raster position counters and output point selection.
// Depends on bs3_pkg.
module bs3_ctrl #(
   parameter int MAX_COLS   = 256,
   parameter int MAX_ROWS   = 256,
   parameter int MAX_PLANES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bs3_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [bs3_pkg::CsrDataWidth-1:0]     csr_wdata,
   input  logic                                 accept,
   output logic [$clog2(MAX_COLS)-1:0]          col_addr,
   output logic [$clog2(MAX_ROWS)-1:0]          row_addr,
   output bs3_pkg::meta_type                    meta,
   output logic [bs3_pkg::ScaleWidth-1:0]       sum_scale
);
   import bs3_pkg::*;

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int PW  = $clog2(MAX_PLANES);
   localparam int NCW = CW + 1;
   localparam int NRW = RW + 1;
   localparam int NPW = PW + 1;

   function automatic int clamp_dim(input int v, input int hi);
      int r;
      r = v;
      if (v < 3) r = 3;
      if (v > hi) r = hi;
      return r;
   endfunction

   // Phase of the step pattern; zero on the first interior index of an axis.
   function automatic logic [StepWidth-1:0] next_phase(input logic [StepWidth-1:0] ph,
                                                       input logic is_two,
                                                       input logic [StepWidth-1:0] s);
      logic [StepWidth-1:0] r;
      if (is_two || ph == s - 1'b1) r = '0;
      else r = ph + 1'b1;
      return r;
   endfunction

   logic [NCW-1:0]        nc_ff;
   logic [NRW-1:0]        nr_ff;
   logic [NPW-1:0]        np_ff;
   logic [StepWidth-1:0]  s_ff;
   logic [ScaleWidth-1:0] scale_ff;
   logic [CW-1:0]         c_ff, c_in;
   logic [RW-1:0]         r_ff, r_in;
   logic [PW-1:0]         p_ff, p_in;
   logic [StepWidth-1:0]  cph_ff, cph_in, rph_ff, rph_in, pph_ff, pph_in;
   logic                  c_last, r_last, p_last;
   logic [31:0]           col_m1, row_m1, plane_m1;

   assign c_last = {1'b0, c_ff} == nc_ff - 1'b1;
   assign r_last = {1'b0, r_ff} == nr_ff - 1'b1;
   assign p_last = {1'b0, p_ff} == np_ff - 1'b1;

   always_comb begin
      c_in   = c_ff;
      r_in   = r_ff;
      p_in   = p_ff;
      cph_in = cph_ff;
      rph_in = rph_ff;
      pph_in = pph_ff;
      if (c_last) begin
         c_in = '0;
         if (r_last) begin
            r_in = '0;
            if (p_last) begin
               p_in = '0;
            end else begin
               p_in   = p_ff + 1'b1;
               pph_in = next_phase(pph_ff, p_in == PW'(2), s_ff);
            end
         end else begin
            r_in   = r_ff + 1'b1;
            rph_in = next_phase(rph_ff, r_in == RW'(2), s_ff);
         end
      end else begin
         c_in   = c_ff + 1'b1;
         cph_in = next_phase(cph_ff, c_in == CW'(2), s_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff    <= NCW'(clamp_dim(DimReset, MAX_COLS));
         nr_ff    <= NRW'(clamp_dim(DimReset, MAX_ROWS));
         np_ff    <= NPW'(clamp_dim(PlaneReset, MAX_PLANES));
         s_ff     <= StepReset;
         scale_ff <= ScaleReset;
         c_ff     <= '0;
         r_ff     <= '0;
         p_ff     <= '0;
         cph_ff   <= '0;
         rph_ff   <= '0;
         pph_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrVolumeCols: begin
               nc_ff <= NCW'(clamp_dim(int'(csr_wdata[8:0]), MAX_COLS));
            end
            CsrVolumeRows: begin
               nr_ff <= NRW'(clamp_dim(int'(csr_wdata[8:0]), MAX_ROWS));
            end
            CsrVolumePlanes: begin
               np_ff <= NPW'(clamp_dim(int'(csr_wdata[10:0]), MAX_PLANES));
            end
            CsrStepSize: begin
               s_ff <= (csr_wdata[7:0] == '0) ? StepReset : csr_wdata[7:0];
            end
            CsrSumScale: begin
               scale_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
         // A geometry write restarts the volume; a weight write does not.
         if (csr_index == CsrVolumeCols || csr_index == CsrVolumeRows ||
             csr_index == CsrVolumePlanes || csr_index == CsrStepSize) begin
            c_ff   <= '0;
            r_ff   <= '0;
            p_ff   <= '0;
            cph_ff <= '0;
            rph_ff <= '0;
            pph_ff <= '0;
         end
      end else if (accept) begin
         c_ff   <= c_in;
         r_ff   <= r_in;
         p_ff   <= p_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
         pph_ff <= pph_in;
      end
   end

   assign col_m1   = 32'(c_ff) - 32'd1;
   assign row_m1   = 32'(r_ff) - 32'd1;
   assign plane_m1 = 32'(p_ff) - 32'd1;

   assign col_addr   = c_ff;
   assign row_addr   = r_ff;
   assign sum_scale  = scale_ff;
   assign meta.emit  = c_ff >= CW'(2) && r_ff >= RW'(2) && p_ff >= PW'(2) &&
                       cph_ff == '0 && rph_ff == '0 && pph_ff == '0;
   assign meta.last  = (32'(c_ff) + 32'(s_ff) >= 32'(nc_ff)) &&
                       (32'(r_ff) + 32'(s_ff) >= 32'(nr_ff)) &&
                       (32'(p_ff) + 32'(s_ff) >= 32'(np_ff));
   assign meta.col   = col_m1[ColPosWidth-1:0];
   assign meta.row   = row_m1[RowPosWidth-1:0];
   assign meta.plane = plane_m1[PlanePosWidth-1:0];

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, c_ff} < nc_ff && {1'b0, r_ff} < nr_ff && {1'b0, p_ff} < np_ff)
      else $error("position counter beyond the volume geometry");

   a_volume_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_we && c_last && r_last && p_last |=> c_ff == '0 && r_ff == '0 && p_ff == '0)
      else $error("counters did not wrap after the last sample of the volume");

endmodule

// File: rtl/core/bs3_delay.sv
`timescale 1ns / 1ps
// Row and plane delay memories: forms the nine-sample column sum at each position.
// Depends on bs3_pkg.
module bs3_delay #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [bs3_pkg::SampleWidth-1:0] in_sample,
   input  logic [$clog2(MAX_COLS)-1:0]            col_addr,
   input  logic [$clog2(MAX_ROWS)-1:0]            row_addr,
   input  bs3_pkg::meta_type                      in_meta,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [bs3_pkg::ColWidth-1:0]    out_sum,
   output bs3_pkg::meta_type                      out_meta
);
   import bs3_pkg::*;

   localparam int CW       = $clog2(MAX_COLS);
   localparam int AW       = $clog2(MAX_COLS) + $clog2(MAX_ROWS);
   localparam int LbDepth  = 2 ** CW;
   localparam int PmDepth  = 2 ** AW;

   // lb1/lb2 hold the previous two rows of this plane; pm1/pm2 hold the
   // three-row vertical sums of the previous two planes.
   logic signed [SampleWidth-1:0] lb1_mem [LbDepth];
   logic signed [SampleWidth-1:0] lb2_mem [LbDepth];
   logic signed [VertWidth-1:0]   pm1_mem [PmDepth];
   logic signed [VertWidth-1:0]   pm2_mem [PmDepth];

   logic                          accept, en1, fire1, en2, fire2;
   logic                          v1_ff, v2_ff;
   logic signed [SampleWidth-1:0] x1_ff, lb1_rd_ff, lb2_rd_ff;
   logic signed [VertWidth-1:0]   pm1_rd_ff, pm2_rd_ff, pm1_d2_ff, pm2_d2_ff;
   logic signed [VertWidth-1:0]   vert_in, vert2_ff;
   logic [CW-1:0]                 c1_ff;
   logic [AW-1:0]                 rd_addr, a1_ff, a2_ff;
   meta_type                      meta1_ff, meta2_ff;

   assign rd_addr  = {row_addr, col_addr};
   assign en2      = !v2_ff || out_ready;
   assign fire2    = v2_ff && out_ready;
   assign en1      = !v1_ff || en2;
   assign fire1    = v1_ff && en2;
   assign in_ready = en1;
   assign accept   = in_valid && en1;

   always_ff @(posedge clock) begin
      if (fire1) lb1_mem[c1_ff] <= x1_ff;
      if (accept) lb1_rd_ff <= lb1_mem[col_addr];
   end

   always_ff @(posedge clock) begin
      if (fire1) lb2_mem[c1_ff] <= lb1_rd_ff;
      if (accept) lb2_rd_ff <= lb2_mem[col_addr];
   end

   always_ff @(posedge clock) begin
      if (fire2) pm1_mem[a2_ff] <= vert2_ff;
      if (accept) pm1_rd_ff <= pm1_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (fire2) pm2_mem[a2_ff] <= pm1_d2_ff;
      if (accept) pm2_rd_ff <= pm2_mem[rd_addr];
   end

   assign vert_in = VertWidth'(x1_ff) + VertWidth'(lb1_rd_ff) + VertWidth'(lb2_rd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x1_ff    <= in_sample;
         c1_ff    <= col_addr;
         a1_ff    <= rd_addr;
         meta1_ff <= in_meta;
      end
      if (fire1) begin
         vert2_ff  <= vert_in;
         pm1_d2_ff <= pm1_rd_ff;
         pm2_d2_ff <= pm2_rd_ff;
         a2_ff     <= a1_ff;
         meta2_ff  <= meta1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_meta  = meta2_ff;
   assign out_sum   = ColWidth'(vert2_ff) + ColWidth'(pm1_d2_ff) + ColWidth'(pm2_d2_ff);

   a_lb_no_collision: assert property (@(posedge clock) disable iff (reset)
      accept && fire1 |-> col_addr != c1_ff)
      else $error("row delay read and write hit the same column in one cycle");

   a_pm_no_collision: assert property (@(posedge clock) disable iff (reset)
      accept && fire2 |-> rd_addr != a2_ff)
      else $error("plane delay read and write hit the same entry in one cycle");

endmodule

// File: rtl/core/bs3_reduce.sv
`timescale 1ns / 1ps
// Horizontal three-column sum, weighting, rounding, saturation and result register.
// Depends on bs3_pkg.
module bs3_reduce (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [bs3_pkg::ColWidth-1:0]    in_sum,
   input  bs3_pkg::meta_type                      in_meta,
   input  logic [bs3_pkg::ScaleWidth-1:0]         sum_scale,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [bs3_pkg::SampleWidth-1:0] rsp_filtered,
   output logic [bs3_pkg::ColPosWidth-1:0]        rsp_col_pos,
   output logic [bs3_pkg::RowPosWidth-1:0]        rsp_row_pos,
   output logic [bs3_pkg::PlanePosWidth-1:0]      rsp_plane_pos,
   output logic                                   rsp_volume_done
);
   import bs3_pkg::*;

   localparam logic signed [ProdWidth-1:0] RoundHalf = ProdWidth'(32768);
   localparam logic signed [ProdWidth-1:0] SatMax    = ProdWidth'(64'sd2147483647);
   localparam logic signed [ProdWidth-1:0] SatMin    = -ProdWidth'(64'sd2147483648);

   logic                          v3_ff, v4_ff, v5_ff, out_valid_ff;
   logic                          en3, fire3, en4, fire4, en5, fire5, en_out;
   logic signed [ColWidth-1:0]    w3_ff, wq1_ff, wq2_ff;
   logic signed [TotalWidth-1:0]  total_in, total4_ff;
   logic signed [ProdWidth-1:0]   prod_in, prod5_ff, rounded, shifted;
   logic signed [SampleWidth-1:0] sat_in, filt_ff;
   meta_type                      meta3_ff, meta4_ff, meta5_ff, meta_out_ff;

   assign en_out   = !out_valid_ff || !rsp_stall;
   // Beats that select no output point leave the pipeline here.
   assign en5      = !v5_ff || !meta5_ff.emit || en_out;
   assign fire5    = v5_ff && meta5_ff.emit && en_out;
   assign en4      = !v4_ff || en5;
   assign fire4    = v4_ff && en5;
   assign en3      = !v3_ff || en4;
   assign fire3    = v3_ff && en4;
   assign in_ready = en3;

   assign total_in = TotalWidth'(w3_ff) + TotalWidth'(wq1_ff) + TotalWidth'(wq2_ff);
   assign prod_in  = ProdWidth'(total4_ff) * ProdWidth'($signed({1'b0, sum_scale}));
   assign rounded  = prod5_ff + RoundHalf;
   assign shifted  = rounded >>> 16;

   always_comb begin
      if (shifted > SatMax) sat_in = SatMax[SampleWidth-1:0];
      else if (shifted < SatMin) sat_in = SatMin[SampleWidth-1:0];
      else sat_in = shifted[SampleWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en3) v3_ff <= in_valid;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en_out) out_valid_ff <= v5_ff && meta5_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && en3) begin
         w3_ff    <= in_sum;
         meta3_ff <= in_meta;
      end
      // The column history shifts once per beat, so it always holds the two
      // columns to the left of the beat in the third stage.
      if (fire3) begin
         wq1_ff    <= w3_ff;
         wq2_ff    <= wq1_ff;
         total4_ff <= total_in;
         meta4_ff  <= meta3_ff;
      end
      if (fire4) begin
         prod5_ff <= prod_in;
         meta5_ff <= meta4_ff;
      end
      if (fire5) begin
         filt_ff     <= sat_in;
         meta_out_ff <= meta5_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_filtered    = filt_ff;
   assign rsp_col_pos     = meta_out_ff.col;
   assign rsp_row_pos     = meta_out_ff.row;
   assign rsp_plane_pos   = meta_out_ff.plane;
   assign rsp_volume_done = meta_out_ff.last;

   a_blocked_only_by_output: assert property (@(posedge clock) disable iff (reset)
      v5_ff && !en5 |-> out_valid_ff && rsp_stall && meta5_ff.emit)
      else $error("final stage held without a stalled result");

   a_result_marked: assert property (@(posedge clock) disable iff (reset)
      fire5 |=> out_valid_ff && meta_out_ff.emit)
      else $error("result register loaded from a beat with no output point");

endmodule

// File: rtl/core/box_stencil_3d_27point_core.sv
`timescale 1ns / 1ps
// Top level of the 3x3x3 box stencil: counters, delay memories and reduction.
// Depends on bs3_pkg, bs3_ctrl, bs3_delay and bs3_reduce.
//
//  Channel  Direction  Handshake           Payload
//  req      in         req_valid/req_stall  req_sample
//  rsp      out        rsp_valid/rsp_stall  rsp_filtered, rsp_col_pos, rsp_row_pos,
//                                           rsp_plane_pos, rsp_volume_done
//  csr      in         csr_we               csr_index, csr_wdata
//
// One sample beat is taken every cycle unless a stalled result backs up to the input. A
// selected point's result is presented once the beat completing its cube has passed
// five pipeline stages (two memory stages, column sum, 27-sample sum, multiply) and
// has been rounded and saturated into the result register.
// Reset is synchronous; the delay memories need no clearing after it.
// A stalled result holds only the stages behind it that are occupied, so empty
// stages keep taking beats while the result waits.
module box_stencil_3d_27point_core #(
   parameter int MAX_COLS   = 256,
   parameter int MAX_ROWS   = 256,
   parameter int MAX_PLANES = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [bs3_pkg::SampleWidth-1:0]   req_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [bs3_pkg::SampleWidth-1:0]   rsp_filtered,
   output logic [bs3_pkg::ColPosWidth-1:0]          rsp_col_pos,
   output logic [bs3_pkg::RowPosWidth-1:0]          rsp_row_pos,
   output logic [bs3_pkg::PlanePosWidth-1:0]        rsp_plane_pos,
   output logic                                     rsp_volume_done,
   input  logic                                     csr_we,
   input  logic [bs3_pkg::CsrIndexWidth-1:0]        csr_index,
   input  logic [bs3_pkg::CsrDataWidth-1:0]         csr_wdata
);
   import bs3_pkg::*;

   logic                          in_ready, accept;
   logic [$clog2(MAX_COLS)-1:0]   col_addr;
   logic [$clog2(MAX_ROWS)-1:0]   row_addr;
   meta_type                      in_meta, sum_meta;
   logic [ScaleWidth-1:0]         sum_scale;
   logic                          sum_valid, sum_ready;
   logic signed [ColWidth-1:0]    col_sum;

   assign req_stall = !in_ready;
   assign accept    = req_valid && in_ready;

   bs3_ctrl #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .MAX_PLANES (MAX_PLANES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .col_addr  (col_addr),
      .row_addr  (row_addr),
      .meta      (in_meta),
      .sum_scale (sum_scale)
   );

   bs3_delay #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_delay (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_sample (req_sample),
      .col_addr  (col_addr),
      .row_addr  (row_addr),
      .in_meta   (in_meta),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (col_sum),
      .out_meta  (sum_meta)
   );

   bs3_reduce u_reduce (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (sum_valid),
      .in_ready        (sum_ready),
      .in_sum          (col_sum),
      .in_meta         (sum_meta),
      .sum_scale       (sum_scale),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_filtered    (rsp_filtered),
      .rsp_col_pos     (rsp_col_pos),
      .rsp_row_pos     (rsp_row_pos),
      .rsp_plane_pos   (rsp_plane_pos),
      .rsp_volume_done (rsp_volume_done)
   );

endmodule

// File: tb/box_stencil_3d_27point_checker.sv
`timescale 1ns / 1ps
// Checker for the 3x3x3 box stencil core: watches both channels and the register port.
// It predicts each filtered point and compares results in order. Depends on bs3_pkg.
module box_stencil_3d_27point_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [bs3_pkg::SampleWidth-1:0] req_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [bs3_pkg::SampleWidth-1:0] rsp_filtered,
   input  logic [bs3_pkg::ColPosWidth-1:0]        rsp_col_pos,
   input  logic [bs3_pkg::RowPosWidth-1:0]        rsp_row_pos,
   input  logic [bs3_pkg::PlanePosWidth-1:0]      rsp_plane_pos,
   input  logic                                   rsp_volume_done,
   input  logic                                   csr_we,
   input  logic [bs3_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [bs3_pkg::CsrDataWidth-1:0]       csr_wdata,
   output int                                     pending,
   output int                                     fail_count
);
   import bs3_pkg::*;

   localparam int MaxCols   = 256;
   localparam int MaxRows   = 256;
   localparam int MaxPlanes = 1024;

   typedef struct {
      logic signed [SampleWidth-1:0] filtered;
      logic [ColPosWidth-1:0]        col;
      logic [RowPosWidth-1:0]        row;
      logic [PlanePosWidth-1:0]      plane;
      logic                          done;
   } box_point_type;

   box_point_type expected_points[$];
   logic [31:0]   recent_planes [3][MaxRows][MaxCols];
   int unsigned   cols_cfg, rows_cfg, planes_cfg, step_cfg, weight_cfg;
   int unsigned   col_at, row_at, plane_at;
   int            errors;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   // Stores one sample and, where it completes a selected cube, queues the filtered point.
   function automatic void take_sample(logic [31:0] sample);
      int unsigned   nc, nr, np, s, c, r, p;
      longint        sum, t;
      box_point_type pt;
      nc = clamp_dim(cols_cfg, MaxCols);
      nr = clamp_dim(rows_cfg, MaxRows);
      np = clamp_dim(planes_cfg, MaxPlanes);
      s  = (step_cfg == 0) ? 1 : step_cfg;
      c  = (col_at >= nc) ? 0 : col_at;
      r  = (row_at >= nr) ? 0 : row_at;
      p  = (plane_at >= np) ? 0 : plane_at;
      recent_planes[p % 3][r][c] = sample;
      if (p >= 2 && r >= 2 && c >= 2 &&
          (p - 2) % s == 0 && (r - 2) % s == 0 && (c - 2) % s == 0) begin
         sum = 0;
         for (int dp = 0; dp < 3; dp++)
            for (int dr = 0; dr < 3; dr++)
               for (int dc = 0; dc < 3; dc++)
                  sum += longint'($signed(recent_planes[(p + 3 - dp) % 3][r - dr][c - dc]));
         // An arithmetic shift of a signed value floors, which gives ties toward +infinity.
         t = (sum * longint'(weight_cfg) + 32768) >>> 16;
         if (t > 64'sd2147483647) t = 64'sd2147483647;
         if (t < -64'sd2147483648) t = -64'sd2147483648;
         pt.filtered = t[31:0];
         pt.col      = ColPosWidth'(c - 1);
         pt.row      = RowPosWidth'(r - 1);
         pt.plane    = PlanePosWidth'(p - 1);
         pt.done     = (c - 1 + s >= nc - 1) && (r - 1 + s >= nr - 1) &&
                       (p - 1 + s >= np - 1);
         expected_points.push_back(pt);
      end
      c++;
      if (c >= nc) begin
         c = 0;
         r++;
         if (r >= nr) begin
            r = 0;
            p++;
            if (p >= np) p = 0;
         end
      end
      col_at   = c;
      row_at   = r;
      plane_at = p;
   endfunction

   function automatic void write_register(logic [CsrIndexWidth-1:0] idx,
                                          logic [CsrDataWidth-1:0] data);
      case (idx)
         CsrVolumeCols:   cols_cfg   = data[8:0];
         CsrVolumeRows:   rows_cfg   = data[8:0];
         CsrVolumePlanes: planes_cfg = data[10:0];
         CsrStepSize:     step_cfg   = data[7:0];
         CsrSumScale: begin
            weight_cfg = data;
            return;
         end
         default: return;
      endcase
      // Any geometry write restarts the volume.
      col_at   = 0;
      row_at   = 0;
      plane_at = 0;
   endfunction

   function automatic void report(string field, longint want, longint got);
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
   endfunction

   always @(posedge clock) begin
      box_point_type want;
      if (reset) begin
         cols_cfg   = DimReset;
         rows_cfg   = DimReset;
         planes_cfg = PlaneReset;
         step_cfg   = StepReset;
         weight_cfg = ScaleReset;
         col_at     = 0;
         row_at     = 0;
         plane_at   = 0;
         expected_points.delete();
      end else begin
         if (csr_we) write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) take_sample(req_sample);
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $display("%0t: result beat with none expected, actual filtered %0d", $time,
                        rsp_filtered);
               errors++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_filtered !== want.filtered)
                  report("filtered", want.filtered, rsp_filtered);
               if (rsp_col_pos !== want.col) report("col_pos", want.col, rsp_col_pos);
               if (rsp_row_pos !== want.row) report("row_pos", want.row, rsp_row_pos);
               if (rsp_plane_pos !== want.plane)
                  report("plane_pos", want.plane, rsp_plane_pos);
               if (rsp_volume_done !== want.done)
                  report("volume_done", want.done, rsp_volume_done);
            end
         end
      end
      pending    <= expected_points.size();
      fail_count <= errors;
   end

endmodule

// File: tb/box_stencil_3d_27point_core_test.sv
`timescale 1ns / 1ps
// Top of the box stencil testbench: clock, reset, sample and register stimulus, verdict.
// Depends on bs3_pkg, box_stencil_3d_27point_core and box_stencil_3d_27point_checker.
module box_stencil_3d_27point_core_test;
   import bs3_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CsrUnusedIndex = 3'd5;
   localparam int                       SettleCycles   = 12;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SampleWidth-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SampleWidth-1:0] rsp_filtered;
   logic [ColPosWidth-1:0]        rsp_col_pos;
   logic [RowPosWidth-1:0]        rsp_row_pos;
   logic [PlanePosWidth-1:0]      rsp_plane_pos;
   logic                          rsp_volume_done;
   logic                          csr_we = 1'b0;
   logic [CsrIndexWidth-1:0]      csr_index = '0;
   logic [CsrDataWidth-1:0]       csr_wdata = '0;
   int                            pending;
   int                            fail_count;
   bit                            allow_idle = 1'b0;
   int                            samples_sent = 0;

   box_stencil_3d_27point_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_filtered(rsp_filtered),
      .rsp_col_pos(rsp_col_pos), .rsp_row_pos(rsp_row_pos), .rsp_plane_pos(rsp_plane_pos),
      .rsp_volume_done(rsp_volume_done),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   box_stencil_3d_27point_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_filtered(rsp_filtered),
      .rsp_col_pos(rsp_col_pos), .rsp_row_pos(rsp_row_pos), .rsp_plane_pos(rsp_plane_pos),
      .rsp_volume_done(rsp_volume_done),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .fail_count(fail_count)
   );

   always #4 clock = ~clock;

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Result back-pressure in random bursts.
   always @(posedge clock) begin
      int stall_left;
      if (stall_left == 0 && allow_idle && $urandom_range(0, 9) == 0)
         stall_left = $urandom_range(1, 7);
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_sample(logic [31:0] value);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   // Waits for every expected point, then for the pipeline to empty. The first edge
   // lets the pending count catch up with the last accepted beat.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(int cols, int rows, int planes, int step);
      csr_write(CsrVolumeCols, CsrDataWidth'(cols));
      csr_write(CsrVolumeRows, CsrDataWidth'(rows));
      csr_write(CsrVolumePlanes, CsrDataWidth'(planes));
      csr_write(CsrStepSize, CsrDataWidth'(step));
   endtask

   // kind: 0 random mix, 1 all maximum, 2 all minimum
   task automatic send_run(int count, int kind);
      for (int i = 0; i < count; i++)
         case (kind)
            1: send_sample(32'h7FFF_FFFF);
            2: send_sample(32'h8000_0000);
            default: send_sample(pick_sample());
         endcase
   endtask

   function automatic int eff_dim(int v, int hi);
      return (v < 3) ? 3 : (v > hi) ? hi : v;
   endfunction

   initial begin
      int cols, rows, planes, step, vol, count;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest cube with the weight at its reset value.
      set_geometry(3, 3, 3, 1);
      send_run(27, 0);
      settle();
      // Saturation at both ends with the full weight.
      csr_write(CsrSumScale, 16'hFFFF);
      set_geometry(3, 3, 3, 1);
      send_run(27, 1);
      send_run(27, 2);
      settle();
      csr_write(CsrSumScale, 16'h0000);
      send_run(27, 0);
      settle();
      // Out-of-range geometry clamps, a zero step acts as one, unknown index is ignored.
      csr_write(CsrSumScale, 16'h8000);
      set_geometry(0, 1, 2, 0);
      csr_write(CsrUnusedIndex, 16'hFFFF);
      send_run(30, 0);
      settle();

      allow_idle = 1'b1;
      // Longer rows, taller planes and a deeper volume.
      set_geometry(24, 3, 3, 1);
      send_run(24 * 9, 0);
      settle();
      set_geometry(3, 24, 3, 2);
      send_run(24 * 9, 0);
      settle();
      set_geometry(3, 3, 24, 255);
      send_run(9 * 24, 0);
      settle();

      while (samples_sent < 1500) begin
         allow_idle = (samples_sent < 1200) && ($urandom_range(0, 3) != 0);
         cols   = $urandom_range(3, 9);
         rows   = $urandom_range(3, 7);
         planes = $urandom_range(3, 6);
         case ($urandom_range(0, 9))
            0: step = 0;
            1: step = 255;
            2, 3: step = $urandom_range(2, 3);
            default: step = 1;
         endcase
         if ($urandom_range(0, 19) == 0) cols = $urandom_range(0, 2);
         if ($urandom_range(0, 19) == 0) rows = $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0)
            case ($urandom_range(0, 2))
               0: csr_write(CsrSumScale, 16'hFFFF);
               1: csr_write(CsrSumScale, 16'h0000);
               default: csr_write(CsrSumScale, CsrDataWidth'($urandom));
            endcase
         set_geometry(cols, rows, planes, step);
         vol = eff_dim(cols, 256) * eff_dim(rows, 256) * eff_dim(planes, 1024);
         // Mostly whole volumes, sometimes two back to back, sometimes cut short.
         count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, vol)
                                             : vol * $urandom_range(1, 2);
         send_run(count, 0);
         settle();
      end

      allow_idle = 1'b0;
      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/bs3_pkg.sv
rtl/core/bs3_ctrl.sv
rtl/core/bs3_delay.sv
rtl/core/bs3_reduce.sv
rtl/core/box_stencil_3d_27point_core.sv
tb/box_stencil_3d_27point_checker.sv
tb/box_stencil_3d_27point_core_test.sv
